// ===== rtl/core/bcg_pkg.sv =====
// ----------------------------------------------------------------------------
// bcg_pkg
// Shared constants, register and item codes, and the structs passed between
// the colour lanes, the merge stage and the top level of the pixel adjuster.
// ----------------------------------------------------------------------------
package bcg_pkg;

  // gamma table
  localparam int TABLE_DEPTH = 256;
  localparam int TABLE_AW    = $clog2(TABLE_DEPTH);

  // lanes and pipeline
  localparam int NUM_LANES  = 3;
  localparam int PIPE_DEPTH = 6;

  // output queue, deep enough to cover the pipeline at full rate
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  // arithmetic constants
  localparam int BYTE_MAX     = 255;
  localparam int MID          = 127;
  localparam int DIVISOR      = 50;
  localparam int DIV_SHIFT    = 16;
  localparam int RECIP_50     = 1310;    // just under 2^16/50
  localparam int RECIP_BRIGHT = 334050;  // just under 255*2^16/50

  // configuration register indexes
  localparam logic [1:0] REG_CHANNEL_MASK = 2'd0;
  localparam logic [1:0] REG_BRIGHTNESS   = 2'd1;
  localparam logic [1:0] REG_CONTRAST     = 2'd2;
  localparam logic [1:0] REG_SWAPPED      = 2'd3;

  // item kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_TABLE = 1'b1;

  // channel mask bits
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  typedef struct packed {
    logic                en;
    logic [TABLE_AW-1:0] idx;
    logic [7:0]          val;
  } bcg_twr_t;

  typedef struct packed {
    logic        push;
    logic [31:0] pixel;
  } bcg_beat_t;

endpackage

// ===== rtl/core/brightness_contrast_gamma_pixel.sv =====
// ----------------------------------------------------------------------------
// brightness_contrast_gamma_pixel
// Brightness, contrast and gamma adjustment of an ARGB pixel stream, three
// colour lanes side by side with a shared merge stage and output queue.
// ----------------------------------------------------------------------------
// an accepted pixel passes the lane pipeline and the output queue before it reaches m_tdata
// throughput: one beat per clock while s_tready is high, pixels and table writes alike
// s_tready drops only in reset or when eight pixels are in flight or queued (queue credit)
// reset: registers to defaults, gamma table reads as identity, queue empty
// ----------------------------------------------------------------------------
module brightness_contrast_gamma_pixel
  import bcg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // pixel_in [31:0], table_index [39:32], table_value [47:40]
  input  logic        s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // pixel_out [31:0]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  typedef struct packed {
    logic                kind;
    logic [31:0]         pixel;
    logic [TABLE_AW-1:0] idx;
    logic [7:0]          val;
  } bcg_ctrl_t;

  logic [2:0]               channel_mask;
  logic                     swapped_order;
  logic signed [8:0]        contrast_gain;
  logic                     bright_neg;
  logic [7:0]               bright_abs;
  logic [9:0]               bright_q0;
  logic signed [10:0]       bright_ofs;

  logic [7:0]               cfg_abs;
  logic [26:0]              bprod;
  logic [15:0]              bn;
  logic [15:0]              bq50;
  logic [15:0]              brem;
  logic [10:0]              bq;

  logic                     acc;
  logic                     acc_pix;
  logic                     pop;
  logic [FIFO_CW-1:0]       credit;
  logic [FIFO_CW-1:0]       credit_next;

  logic [PIPE_DEPTH-1:0]    vld_q;
  bcg_ctrl_t                ctrl_in;
  bcg_ctrl_t [PIPE_DEPTH-1:0] ctrl_q;

  bcg_twr_t                 tw;
  bcg_beat_t                beat;
  logic [NUM_LANES-1:0][7:0] lane_res;

  // configuration; the brightness step is registered as a quotient estimate, then corrected and signed
  assign cfg_abs = cfg_data[7] ? 8'(~cfg_data + 8'd1) : cfg_data;
  assign bprod   = 27'(cfg_abs) * 27'(RECIP_BRIGHT);

  assign bn   = {bright_abs, 8'b0} - {8'b0, bright_abs};
  assign bq50 = 16'(bright_q0) * 16'(DIVISOR);
  assign brem = bn - bq50;
  assign bq   = 11'(bright_q0) + ((brem >= 16'(DIVISOR)) ? 11'd1 : 11'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_mask  <= 3'b111;
      swapped_order <= 1'b0;
      contrast_gain <= 9'(DIVISOR);
      bright_neg    <= 1'b0;
      bright_abs    <= '0;
      bright_q0     <= '0;
      bright_ofs    <= '0;
    end else begin
      bright_ofs <= bright_neg ? 11'(-bq) : bq;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CHANNEL_MASK: channel_mask <= cfg_data[2:0];
          REG_BRIGHTNESS: begin
            bright_neg <= cfg_data[7];
            bright_abs <= cfg_abs;
            bright_q0  <= bprod[DIV_SHIFT +: 10];
          end
          REG_CONTRAST: contrast_gain <= $signed({cfg_data[7], cfg_data}) + 9'(DIVISOR);
          REG_SWAPPED:  swapped_order <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // credit covers every pixel between the input and the queue head
  assign s_tready = !rst && (credit < FIFO_CW'(FIFO_DEPTH));
  assign acc      = s_tvalid && s_tready;
  assign acc_pix  = acc && (s_tuser == KIND_PIXEL);
  assign pop      = m_tvalid && m_tready;

  always_comb begin
    unique case ({acc_pix, pop})
      2'b10:   credit_next = credit + FIFO_CW'(1);
      2'b01:   credit_next = credit - FIFO_CW'(1);
      default: credit_next = credit;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
      vld_q  <= '0;
    end else begin
      credit <= credit_next;
      vld_q  <= {vld_q[PIPE_DEPTH-2:0], acc};
    end
  end

  assign ctrl_in = '{kind: s_tuser, pixel: s_tdata[31:0], idx: s_tdata[39:32],
                     val: s_tdata[47:40]};

  always_ff @(posedge clk) begin
    ctrl_q <= {ctrl_q[PIPE_DEPTH-2:0], ctrl_in};
  end

  // table writes reach the lanes in step with the lookup stage
  assign tw.en  = vld_q[PIPE_DEPTH-2] && (ctrl_q[PIPE_DEPTH-2].kind == KIND_TABLE);
  assign tw.idx = ctrl_q[PIPE_DEPTH-2].idx;
  assign tw.val = ctrl_q[PIPE_DEPTH-2].val;

  assign beat.push  = vld_q[PIPE_DEPTH-1] && (ctrl_q[PIPE_DEPTH-1].kind == KIND_PIXEL);
  assign beat.pixel = ctrl_q[PIPE_DEPTH-1].pixel;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    bcg_lane u_lane (
      .clk           (clk),
      .rst           (rst),
      .byte_in       (s_tdata[8*g +: 8]),
      .bright_ofs    (bright_ofs),
      .contrast_gain (contrast_gain),
      .tw            (tw),
      .byte_out      (lane_res[g])
    );
  end

  bcg_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .beat          (beat),
    .lane_res      (lane_res),
    .channel_mask  (channel_mask),
    .swapped_order (swapped_order),
    .m_tready      (m_tready),
    .m_tvalid      (m_tvalid),
    .m_tdata       (m_tdata)
  );

endmodule

// ===== rtl/core/bcg_lane.sv =====
// ----------------------------------------------------------------------------
// bcg_lane
// One colour byte lane: brightness offset and clamp, contrast gain with
// truncating divide by 50 and clamp, then a gamma table lookup. Six stages,
// one byte per clock, no stall.
// ----------------------------------------------------------------------------
module bcg_lane
  import bcg_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          byte_in,
  input  logic signed [10:0]  bright_ofs,
  input  logic signed [8:0]   contrast_gain,
  input  bcg_twr_t            tw,
  output logic [7:0]          byte_out
);

  function automatic logic [7:0] clamp_byte(input logic signed [11:0] v);
    logic [7:0] r;
    priority if (v < $signed(12'd0)) begin
      r = 8'd0;
    end else if (v > $signed(12'(BYTE_MAX))) begin
      r = 8'(BYTE_MAX);
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  logic [7:0]          b1;
  logic [7:0]          x2;
  logic                neg3;
  logic [14:0]         mag3;
  logic                neg4;
  logic [14:0]         mag4;
  logic [9:0]          q4;
  logic [7:0]          addr5;
  logic [7:0]          rd6;
  logic [7:0]          addr6;
  logic                hit6;

  logic signed [11:0]  sum2;
  logic signed [8:0]   diff3;
  logic signed [17:0]  prod3;
  logic [17:0]         abs3;
  logic [25:0]         rprod4;
  logic [14:0]         q50;
  logic [14:0]         rem5;
  logic [10:0]         qf5;
  logic signed [11:0]  v5;

  logic [7:0]             mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] filled;

  // brightness
  assign sum2 = $signed({4'b0000, b1}) + $signed({bright_ofs[10], bright_ofs});

  // contrast product around the mid level
  assign diff3 = $signed({1'b0, x2}) - $signed(9'(MID));
  assign prod3 = diff3 * contrast_gain;
  assign abs3  = prod3[17] ? 18'(-prod3) : 18'(prod3);

  // quotient estimate, at most one low
  assign rprod4 = 26'(mag3) * 26'(RECIP_50);

  // correct the estimate, restore the sign, recentre
  assign q50  = 15'(q4) * 15'(DIVISOR);
  assign rem5 = mag4 - q50;
  assign qf5  = 11'(q4) + ((rem5 >= 15'(DIVISOR)) ? 11'd1 : 11'd0);
  assign v5   = neg4 ? $signed(12'(MID)) - $signed({1'b0, qf5})
                     : $signed(12'(MID)) + $signed({1'b0, qf5});

  always_ff @(posedge clk) begin
    b1    <= byte_in;
    x2    <= clamp_byte(sum2);
    neg3  <= prod3[17];
    mag3  <= abs3[14:0];
    neg4  <= neg3;
    mag4  <= mag3;
    q4    <= rprod4[DIV_SHIFT +: 10];
    addr5 <= clamp_byte(v5);
  end

  // gamma table, entries never written read as identity
  always_ff @(posedge clk) begin
    if (tw.en) begin
      mem[tw.idx] <= tw.val;
    end
    rd6   <= mem[addr5];
    hit6  <= filled[addr5];
    addr6 <= addr5;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
    end else if (tw.en) begin
      filled[tw.idx] <= 1'b1;
    end
  end

  assign byte_out = hit6 ? rd6 : addr6;

endmodule

// ===== rtl/core/bcg_merge.sv =====
// ----------------------------------------------------------------------------
// bcg_merge
// Picks adjusted or original bytes per channel enable, keeps alpha, and
// queues the finished pixel words for the output stream.
// ----------------------------------------------------------------------------
module bcg_merge
  import bcg_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  bcg_beat_t                  beat,
  input  logic [NUM_LANES-1:0][7:0]  lane_res,
  input  logic [2:0]                 channel_mask,
  input  logic                       swapped_order,
  input  logic                       m_tready,
  output logic                       m_tvalid,
  output logic [31:0]                m_tdata
);

  logic               en_hi;
  logic               en_mid;
  logic               en_lo;
  logic [31:0]        word;
  logic               pop;
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_CW-1:0] fill;
  logic [FIFO_CW-1:0] fill_next;
  logic [31:0]        queue [FIFO_DEPTH];

  // red sits in the high byte unless the order is swapped
  assign en_hi  = swapped_order ? channel_mask[CH_BLUE] : channel_mask[CH_RED];
  assign en_mid = channel_mask[CH_GREEN];
  assign en_lo  = swapped_order ? channel_mask[CH_RED] : channel_mask[CH_BLUE];

  assign word = {beat.pixel[31:24],
                 en_hi  ? lane_res[2] : beat.pixel[23:16],
                 en_mid ? lane_res[1] : beat.pixel[15:8],
                 en_lo  ? lane_res[0] : beat.pixel[7:0]};

  assign pop = m_tvalid && m_tready;

  always_comb begin
    unique case ({beat.push, pop})
      2'b10:   fill_next = fill + FIFO_CW'(1);
      2'b01:   fill_next = fill - FIFO_CW'(1);
      default: fill_next = fill;
    endcase
  end

  always_ff @(posedge clk) begin
    if (beat.push) begin
      queue[wr_ptr] <= word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (beat.push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      fill <= fill_next;
    end
  end

  assign m_tvalid = (fill != '0);
  assign m_tdata  = queue[rd_ptr];

endmodule

// ===== rtl/core/bcg_chk.sv =====
// ----------------------------------------------------------------------------
// bcg_chk
// Port-level checks for the pixel adjuster, bound to the top level.
// ----------------------------------------------------------------------------
module bcg_chk
  import bcg_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // queue empties on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // an empty output can only fill from a pixel that was accepted and ran through the pipeline
  a_fixed_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready && (s_tuser == KIND_PIXEL), 7))
    else $error("output appeared without a matching pixel");

  // credit runs out only with results already waiting
  a_credit: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with nothing queued");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output beat changed");

endmodule

bind brightness_contrast_gamma_pixel bcg_chk u_bcg_chk (.*);
